FILE: src/matrix4_inverse_core_assert.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX4_INVERSE_CORE_ASSERT_SVH
`define MATRIX4_INVERSE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MINV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("matrix4 inverse assertion failed");
`define MINV_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("matrix4 inverse assertion failed");
`else
`define MINV_ASSERT(lbl, clk, rst, prop)
`define MINV_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

FILE: src/minv_pkg.sv
// Shared types, index tables and helpers for the matrix inverse core.
package minv_pkg;

   localparam int MAT_N = 16;
   localparam int TERMS = 6;

   // Operand indexes {a, b, c} of the six triple terms of each adjugate entry.
   localparam int ADJ_IDX [16][18] = '{
      '{5,10,15, 5,11,14, 9,6,15, 9,7,14, 13,6,11, 13,7,10},
      '{1,10,15, 1,11,14, 9,2,15, 9,3,14, 13,2,11, 13,3,10},
      '{1,6,15, 1,7,14, 5,2,15, 5,3,14, 13,2,7, 13,3,6},
      '{1,6,11, 1,7,10, 5,2,11, 5,3,10, 9,2,7, 9,3,6},
      '{4,10,15, 4,11,14, 8,6,15, 8,7,14, 12,6,11, 12,7,10},
      '{0,10,15, 0,11,14, 8,2,15, 8,3,14, 12,2,11, 12,3,10},
      '{0,6,15, 0,7,14, 4,2,15, 4,3,14, 12,2,7, 12,3,6},
      '{0,6,11, 0,7,10, 4,2,11, 4,3,10, 8,2,7, 8,3,6},
      '{4,9,15, 4,11,13, 8,5,15, 8,7,13, 12,5,11, 12,7,9},
      '{0,9,15, 0,11,13, 8,1,15, 8,3,13, 12,1,11, 12,3,9},
      '{0,5,15, 0,7,13, 4,1,15, 4,3,13, 12,1,7, 12,3,5},
      '{0,5,11, 0,7,9, 4,1,11, 4,3,9, 8,1,7, 8,3,5},
      '{4,9,14, 4,10,13, 8,5,14, 8,6,13, 12,5,10, 12,6,9},
      '{0,9,14, 0,10,13, 8,1,14, 8,2,13, 12,1,10, 12,2,9},
      '{0,5,14, 0,6,13, 4,1,14, 4,2,13, 12,1,6, 12,2,5},
      '{0,5,10, 0,6,9, 4,1,10, 4,2,9, 8,1,6, 8,2,5}
   };

   // Entries whose sign pattern is inverted, bit per entry.
   localparam logic [15:0] ADJ_NEG = 16'h5A5A;
   // Terms subtracted in the base pattern + - - + + -.
   localparam logic [5:0] TERM_MINUS = 6'b100110;

   typedef struct packed {
      logic done;
      logic clamped;
   } div_stat_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (x < -64'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

endpackage

FILE: src/minv_mul.sv
// Shared 32x32 signed multiplier with a registered product.
module minv_mul (
   input  logic               clock,
   input  logic signed [31:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [63:0] product
);
   logic signed [63:0] product_ff;
   logic signed [63:0] product_in;

   assign product_in = 64'(op_a) * 64'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;
endmodule

FILE: src/minv_div.sv
// Bit-serial restoring divider: Q.F quotient of two signed values, clamped.
module minv_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [63:0]    num,
   input  logic signed [63:0]    den,
   output logic signed [31:0]    quotient,
   output minv_pkg::div_stat_type stat,
   output logic                  busy
);
   localparam int NW = 64 + FRAC_BITS;
   localparam int QB = 33;

   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic [63:0]   den_ff, den_in;
   logic [63:0]   rem_ff, rem_in;
   logic [QB-1:0] low_ff, low_in;
   logic [QB-1:0] quo_ff, quo_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic signed [31:0] q_ff, q_in;
   minv_pkg::div_stat_type stat_ff, stat_in;

   logic [63:0] abs_num, abs_den;
   logic [NW-1:0] numer;
   logic [NW-QB-1:0] numer_hi;
   logic [64:0] rem_sh, rem_sub;
   logic [QB-1:0] quo_next, lim;

   always_comb begin
      abs_num  = num[63] ? 64'(-num) : 64'(num);
      abs_den  = den[63] ? 64'(-den) : 64'(den);
      numer    = NW'(abs_num) << FRAC_BITS;
      numer_hi = numer[NW-1:QB];
      rem_sh   = {rem_ff, low_ff[QB-1]};
      rem_sub  = rem_sh - {1'b0, den_ff};
      quo_next = {quo_ff[QB-2:0], ~rem_sub[64]};
      lim      = neg_ff ? QB'(33'h080000000) : QB'(33'h07FFFFFFF);

      busy_in = busy_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      stat_in = '{done: 1'b0, clamped: stat_ff.clamped};

      if (!busy_ff) begin
         if (start) begin
            neg_in = num[63] ^ den[63];
            den_in = abs_den;
            low_in = numer[QB-1:0];
            quo_in = '0;
            cnt_in = '0;
            if (64'(numer_hi) >= abs_den) begin
               // whole part already past the range: clamp at once
               q_in = (num[63] ^ den[63]) ? 32'sh80000000 : 32'sh7FFFFFFF;
               stat_in = '{done: 1'b1, clamped: 1'b1};
            end else begin
               rem_in  = 64'(numer_hi);
               busy_in = 1'b1;
            end
         end
      end else begin
         if (!rem_sub[64]) rem_in = rem_sub[63:0];
         else rem_in = rem_sh[63:0];
         low_in = {low_ff[QB-2:0], 1'b0};
         quo_in = quo_next;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QB - 1)) begin
            busy_in = 1'b0;
            if (quo_next > lim) begin
               q_in = neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF;
               stat_in = '{done: 1'b1, clamped: 1'b1};
            end else begin
               q_in = neg_ff ? 32'(-quo_next) : quo_next[31:0];
               stat_in = '{done: 1'b1, clamped: 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         stat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         stat_ff <= stat_in;
      end
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
   assign stat     = stat_ff;
   assign busy     = busy_ff;
endmodule

FILE: src/matrix4_inverse_core.sv
// Top level: 4x4 Q.F matrix inverse by adjugate over determinant.
//  channel | dir | tdata                 | tuser                     | tlast
//  req     | in  | element_in [31:0]     | -                         | -
//  rsp     | out | element_out [31:0]    | [0] singular [1] saturated | last_out
// Elements load on req handshakes. After the 16th element the adjugate runs on
// the shared multiplier: 96 triple terms, each read, multiply, pair, multiply,
// accumulate, plus a multiply and accumulate per determinant term. Each result
// takes read, start, 33 serial divider steps, done and emit (done follows start
// on an at-once clamp; a singular matrix goes from start to emit). req_tready is
// low from the 16th element until the last result is in the output register.
// Reset clears control state; the element and cofactor stores need no reset.
`include "matrix4_inverse_core_assert.svh"
module matrix4_inverse_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] element_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] element_out
   output logic [1:0]  rsp_tuser,   // [0] singular, [1] saturated
   output logic        rsp_tlast
);
   typedef enum logic [3:0] {
      S_LOAD, S_RD_BC, S_MUL_BC, S_PAIR, S_MUL_A, S_ACC,
      S_DET_MUL, S_DET_ACC, S_DIV_RD, S_DIV_START, S_DIV_WAIT, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] load_cnt_ff, load_cnt_in;
   logic [3:0] idx_ff, idx_in;
   logic [2:0] term_ff, term_in;
   logic signed [63:0] sum_ff, sum_in;
   logic signed [63:0] det_ff, det_in;
   logic signed [31:0] pair_ff, pair_in;
   logic signed [31:0] q_hold_ff, q_hold_in;
   logic clamp_hold_ff, clamp_hold_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;
   logic rsp_last_ff, rsp_last_in;

   // element store, two registered read ports
   logic [31:0] mat_mem [16];
   logic [3:0]  addr_a, addr_b;
   logic signed [31:0] rd_a_ff, rd_b_ff;
   // cofactor store, one registered read port
   logic [63:0] cof_mem [16];
   logic        cof_we;
   logic signed [63:0] cof_rd_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] product, shifted;
   logic [4:0] slot;
   logic minus;

   logic div_start, div_busy;
   logic signed [31:0] div_q;
   minv_pkg::div_stat_type div_stat;

   logic req_fire, out_free;

   minv_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   minv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (cof_rd_ff),
      .den      (det_ff),
      .quotient (div_q),
      .stat     (div_stat),
      .busy     (div_busy)
   );

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign shifted  = product >>> FRAC_BITS;
   assign slot     = 5'(term_ff) * 5'd3;
   assign minus    = minv_pkg::TERM_MINUS[term_ff] ^ minv_pkg::ADJ_NEG[idx_ff];

   always_comb begin
      state_in      = state_ff;
      load_cnt_in   = load_cnt_ff;
      idx_in        = idx_ff;
      term_in       = term_ff;
      sum_in        = sum_ff;
      det_in        = det_ff;
      pair_in       = pair_ff;
      q_hold_in     = q_hold_ff;
      clamp_hold_in = clamp_hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;
      addr_a        = 4'(minv_pkg::ADJ_IDX[idx_ff][slot]);
      addr_b        = 4'(minv_pkg::ADJ_IDX[idx_ff][slot + 5'd2]);
      mul_a         = rd_a_ff;
      mul_b         = pair_ff;
      cof_we        = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == 4'd15) begin
                  idx_in   = '0;
                  term_in  = '0;
                  det_in   = '0;
                  state_in = S_RD_BC;
               end
            end
         end
         S_RD_BC: begin
            addr_a   = 4'(minv_pkg::ADJ_IDX[idx_ff][slot + 5'd1]);
            state_in = S_MUL_BC;
         end
         S_MUL_BC: begin
            mul_a    = rd_a_ff;
            mul_b    = rd_b_ff;
            state_in = S_PAIR;
         end
         S_PAIR: begin
            pair_in  = minv_pkg::sat32(shifted);
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            addr_a = {2'b00, idx_ff[3:2]};
            sum_in = (term_ff == 3'd0 ? 64'sd0 : sum_ff) + (minus ? -shifted : shifted);
            if (term_ff == 3'(minv_pkg::TERMS - 1)) begin
               cof_we  = 1'b1;
               term_in = '0;
               if (idx_ff[1:0] == 2'd0) begin
                  state_in = S_DET_MUL;
               end else if (idx_ff == 4'd15) begin
                  idx_in   = '0;
                  state_in = S_DIV_RD;
               end else begin
                  idx_in   = idx_ff + 4'd1;
                  state_in = S_RD_BC;
               end
            end else begin
               term_in  = term_ff + 3'd1;
               state_in = S_RD_BC;
            end
         end
         S_DET_MUL: begin
            mul_b    = minv_pkg::sat32(sum_ff);
            state_in = S_DET_ACC;
         end
         S_DET_ACC: begin
            det_in   = det_ff + shifted;
            idx_in   = idx_ff + 4'd1;
            state_in = S_RD_BC;
         end
         S_DIV_RD: begin
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            if (det_ff == 64'sd0) begin
               q_hold_in     = '0;
               clamp_hold_in = 1'b0;
               state_in      = S_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               q_hold_in     = div_q;
               clamp_hold_in = div_stat.clamped;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = q_hold_ff;
               rsp_user_in  = {clamp_hold_ff, det_ff == 64'sd0};
               rsp_last_in  = idx_ff == 4'd15;
               idx_in       = idx_ff + 4'd1;
               state_in     = idx_ff == 4'd15 ? S_LOAD : S_DIV_RD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         load_cnt_ff  <= '0;
         det_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         det_ff       <= det_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      term_ff       <= term_in;
      sum_ff        <= sum_in;
      pair_ff       <= pair_in;
      q_hold_ff     <= q_hold_in;
      clamp_hold_ff <= clamp_hold_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) mat_mem[load_cnt_ff] <= req_tdata;
      rd_a_ff <= mat_mem[addr_a];
      rd_b_ff <= mat_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (cof_we) cof_mem[idx_ff] <= sum_in;
      cof_rd_ff <= cof_mem[idx_ff];
   end

   assign req_tready = state_ff == S_LOAD;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `MINV_ASSERT(a_div_start_idle, clock, reset, !(div_start && div_busy))
   `MINV_ASSERT(a_singular_zero, clock, reset,
      !(rsp_valid_ff && rsp_user_ff[0]) || (rsp_data_ff == 32'd0 && !rsp_user_ff[1]))
   `MINV_ASSERT_NEXT(a_det_hold, clock, reset,
      state_ff == S_DIV_WAIT || state_ff == S_EMIT, $stable(det_ff))
   `MINV_ASSERT(a_no_load_busy, clock, reset, !(req_fire && div_busy))
endmodule
